// ----- hdl/tlbpt_pkg.sv -----
package tlbpt_pkg;

  localparam int unsigned AddrWidth = 16;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } store_ctrl_t;

endpackage

// ----- hdl/tlbpt_cell.sv -----
module tlbpt_cell #(
  parameter int unsigned PAGE_W  = 8,
  parameter int unsigned FRAME_W = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  logic               valid_i,
  input  logic [PAGE_W-1:0]  tag_i,
  input  logic [FRAME_W-1:0] frame_i,
  input  logic [PAGE_W-1:0]  query_i,
  output logic               valid_o,
  output logic [PAGE_W-1:0]  tag_o,
  output logic [FRAME_W-1:0] frame_o,
  output logic               hit_o,
  output logic [FRAME_W-1:0] hit_frame_o
);

  logic               valid_q;
  logic               valid_d;
  logic [PAGE_W-1:0]  tag_q;
  logic [FRAME_W-1:0] frame_q;

  assign valid_d = shift_i ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      tag_q   <= tag_i;
      frame_q <= frame_i;
    end
  end

  assign hit_o       = valid_q && (tag_q == query_i);
  assign hit_frame_o = hit_o ? frame_q : '0;
  assign valid_o     = valid_q;
  assign tag_o       = tag_q;
  assign frame_o     = frame_q;

endmodule

// ----- hdl/tlbpt_page_store.sv -----
module tlbpt_page_store
  import tlbpt_pkg::*;
#(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned DATA_W = 9,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  store_ctrl_t       ctrl_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic [DATA_W-1:0] rd_data_o,
  output logic              clr_done_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q;
  logic              clr_busy_q;
  logic              clr_busy_d;
  logic [AddrW-1:0]  clr_cnt_q;
  logic [AddrW-1:0]  clr_cnt_d;
  logic              clr_last;

  assign clr_last   = (clr_cnt_q == AddrW'(DEPTH - 1));
  assign clr_busy_d = clr_busy_q && !clr_last;
  assign clr_cnt_d  = clr_busy_q ? clr_cnt_q + 1'b1 : clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (ctrl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_q;
  assign clr_done_o = !clr_busy_q;

endmodule

// ----- hdl/tlb_page_table_translator_core.sv -----
// Address translator: FIFO-replaced TLB in front of a demand-paged page table.
// Input channel: in_valid_i / in_stall_o carry one logical address a beat.
// Output channel: out_valid_o / out_stall_i carry physical address, TLB hit
// flag and page fault flag, one beat for every input beat, in order.
// The TLB is a shift chain of TLB_ENTRIES cells; a miss shifts the new
// mapping in at the head and the oldest one drops off the tail. The page
// table is a RAM with one write port and one registered read port.
// Sequence: when PAGE_COUNT >= 2**(16 - OFFSET_WIDTH) an item is accepted
// (page table read) and then resolved (TLB compare and page table update);
// otherwise a page reduction step between them does the page table read.
// The result appears on the output the cycle after the item resolves.
// Reset: after rst_ni rises the page table is cleared one entry a cycle,
// all PAGE_COUNT entries, with in_stall_o held high throughout.
// Back-pressure: the output register holds a stalled beat; one further item
// is accepted and waits in its resolve state until the output frees.
module tlb_page_table_translator_core
  import tlbpt_pkg::*;
#(
  parameter int unsigned TLB_ENTRIES  = 16,
  parameter int unsigned PAGE_COUNT   = 256,
  parameter int unsigned OFFSET_WIDTH = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [AddrWidth-1:0] logical_address_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [AddrWidth-1:0] physical_address_o,
  output logic                 tlb_hit_o,
  output logic                 page_fault_o
);

  localparam int unsigned PageW  = $clog2(PAGE_COUNT);
  localparam int unsigned FrameW = PageW;
  localparam int unsigned FreeW  = $clog2(PAGE_COUNT + 1);
  localparam int unsigned RawW   = (OFFSET_WIDTH >= AddrWidth) ? 1
                                                               : AddrWidth - OFFSET_WIDTH;
  localparam bit          NeedMod = ((1 << RawW) > PAGE_COUNT);
  localparam int unsigned Recip   = (1 << RawW) / PAGE_COUNT;
  localparam int unsigned PhysW   = FrameW + OFFSET_WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_PAGE    = 3'b010,
    ST_RESOLVE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [AddrWidth-1:0]    addr_shift;
  logic [RawW-1:0]         raw_in;
  logic [2*RawW-1:0]       q_prod;
  logic [RawW-1:0]         q_in;
  logic [PageW-1:0]        page_direct;
  logic [2*RawW-1:0]       qn_prod;
  logic [RawW-1:0]         rem;
  logic [PageW-1:0]        page_mod;

  logic [RawW-1:0]         raw_q;
  logic [RawW-1:0]         q_q;
  logic [OFFSET_WIDTH-1:0] off_q;
  logic [PageW-1:0]        page_q;
  logic [PageW-1:0]        page_d;

  logic                    accept;
  logic                    resolve;
  logic                    clr_done;
  store_ctrl_t             st_ctrl;
  logic [PageW-1:0]        st_rd_addr;
  logic [FrameW:0]         st_rd_data;
  logic                    pt_valid;
  logic [FrameW-1:0]       pt_frame;

  logic [FreeW-1:0]        next_free_q;
  logic [FreeW-1:0]        next_free_d;

  logic                    hit_any;
  logic [FrameW-1:0]       hit_frame;
  logic                    fault;
  logic [FrameW-1:0]       res_frame;
  logic [PhysW-1:0]        phys_full;

  logic                    out_valid_q;
  logic                    out_valid_d;
  logic [AddrWidth-1:0]    phys_q;
  logic                    hit_q;
  logic                    fault_q;

  logic [TLB_ENTRIES-1:0]  link_valid;
  logic [PageW-1:0]        link_tag [TLB_ENTRIES];
  logic [FrameW-1:0]       link_frame [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0]  cell_valid;
  logic [PageW-1:0]        cell_tag [TLB_ENTRIES];
  logic [FrameW-1:0]       cell_frame [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0]  cell_hit;
  logic [FrameW-1:0]       cell_hit_frame [TLB_ENTRIES];
  logic                    tlb_shift;

  // page number and its reduction modulo PAGE_COUNT
  assign addr_shift  = logical_address_i >> OFFSET_WIDTH;
  assign raw_in      = addr_shift[RawW-1:0];
  assign q_prod      = (2*RawW)'(raw_in) * (2*RawW)'(Recip);
  assign q_in        = q_prod[2*RawW-1:RawW];
  assign page_direct = PageW'(raw_in);
  assign qn_prod     = (2*RawW)'(q_q) * (2*RawW)'(PAGE_COUNT);
  assign rem         = raw_q - qn_prod[RawW-1:0];
  assign page_mod    = (rem >= RawW'(PAGE_COUNT)) ? PageW'(rem - RawW'(PAGE_COUNT))
                                                  : PageW'(rem);

  assign in_stall_o = !((state_q == ST_IDLE) && clr_done);
  assign accept     = in_valid_i && !in_stall_o;
  assign resolve    = (state_q == ST_RESOLVE) && !(out_valid_q && out_stall_i);

  always_comb begin
    state_d = state_q;
    page_d  = page_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = NeedMod ? ST_PAGE : ST_RESOLVE;
          page_d  = page_direct;
        end
      end
      ST_PAGE: begin
        state_d = ST_RESOLVE;
        page_d  = page_mod;
      end
      ST_RESOLVE: begin
        if (resolve) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // TLB lookup across the cell chain
  always_comb begin
    hit_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      hit_frame = hit_frame | cell_hit_frame[i];
    end
  end
  assign hit_any = |cell_hit;

  assign pt_valid  = st_rd_data[FrameW];
  assign pt_frame  = st_rd_data[FrameW-1:0];
  assign fault     = !hit_any && !pt_valid;
  assign res_frame = hit_any  ? hit_frame :
                     pt_valid ? pt_frame  : FrameW'(next_free_q);
  assign phys_full = {res_frame, off_q};
  assign tlb_shift = resolve && !hit_any;

  assign next_free_d = (resolve && fault && (next_free_q < FreeW'(PAGE_COUNT)))
                     ? next_free_q + 1'b1 : next_free_q;

  assign st_ctrl.rd_en = (accept && !NeedMod) || (state_q == ST_PAGE);
  assign st_ctrl.wr_en = resolve && fault;
  assign st_rd_addr    = (state_q == ST_PAGE) ? page_mod : page_direct;

  assign out_valid_d = resolve || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      next_free_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_free_q <= next_free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      raw_q <= raw_in;
      q_q   <= q_in;
      off_q <= logical_address_i[OFFSET_WIDTH-1:0];
    end
    page_q <= page_d;
    if (resolve) begin
      phys_q  <= AddrWidth'(phys_full);
      hit_q   <= hit_any;
      fault_q <= fault;
    end
  end

  tlbpt_page_store #(
    .DEPTH  (PAGE_COUNT),
    .DATA_W (FrameW + 1)
  ) u_page_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (st_ctrl),
    .rd_addr_i  (st_rd_addr),
    .wr_addr_i  (page_q),
    .wr_data_i  ({1'b1, res_frame}),
    .rd_data_o  (st_rd_data),
    .clr_done_o (clr_done)
  );

  for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign link_valid[i] = 1'b1;
      assign link_tag[i]   = page_q;
      assign link_frame[i] = res_frame;
    end else begin : g_link
      assign link_valid[i] = cell_valid[i-1];
      assign link_tag[i]   = cell_tag[i-1];
      assign link_frame[i] = cell_frame[i-1];
    end

    tlbpt_cell #(
      .PAGE_W  (PageW),
      .FRAME_W (FrameW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (tlb_shift),
      .valid_i     (link_valid[i]),
      .tag_i       (link_tag[i]),
      .frame_i     (link_frame[i]),
      .query_i     (page_q),
      .valid_o     (cell_valid[i]),
      .tag_o       (cell_tag[i]),
      .frame_o     (cell_frame[i]),
      .hit_o       (cell_hit[i]),
      .hit_frame_o (cell_hit_frame[i])
    );
  end

  assign out_valid_o        = out_valid_q;
  assign physical_address_o = phys_q;
  assign tlb_hit_o          = hit_q;
  assign page_fault_o       = fault_q;

`ifndef SYNTHESIS
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_hit))
    else $error("more than one TLB cell holds the same page");

  a_fill_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid + TLB_ENTRIES'(1)) & cell_valid) == '0)
    else $error("TLB cells not filled from the head");

  a_hit_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(tlb_hit_o && page_fault_o))
    else $error("beat flags both hit and fault");

  a_frame_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (resolve && fault) |-> (next_free_q < FreeW'(PAGE_COUNT)))
    else $error("page fault with no free frame left");
`endif

endmodule

// ----- tb/sv/tlb_page_table_translator_checker.sv -----
`timescale 1ns / 100ps

module tlb_page_table_translator_checker
  import tlbpt_pkg::*;
#(
  parameter int unsigned TLB_ENTRIES  = 16,
  parameter int unsigned PAGE_COUNT   = 256,
  parameter int unsigned OFFSET_WIDTH = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [AddrWidth-1:0] logical_address_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [AddrWidth-1:0] physical_address_i,
  input  logic                 tlb_hit_i,
  input  logic                 page_fault_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          outstanding_o,
  output int unsigned          hit_count_o,
  output int unsigned          fault_count_o
);

  localparam int unsigned PageW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned NextW = $clog2(PAGE_COUNT + 1);

  typedef struct packed {
    logic [AddrWidth-1:0] phys_addr;
    logic                 tlb_hit;
    logic                 page_fault;
  } xlat_t;

  xlat_t            pending_xlats[$];
  xlat_t            want;
  xlat_t            got;
  logic [PageW-1:0] tlb_tag [TLB_ENTRIES];
  logic [PageW-1:0] tlb_frm [TLB_ENTRIES];
  int unsigned      tlb_fill;
  int unsigned      tlb_ptr;
  logic             page_mapped [PAGE_COUNT];
  logic [PageW-1:0] page_frm [PAGE_COUNT];
  logic [NextW-1:0] free_frame;
  int unsigned      mismatches;
  int unsigned      hits;
  int unsigned      faults;

  function automatic xlat_t translate(input logic [AddrWidth-1:0] laddr);
    logic [AddrWidth-1:0] offset;
    int unsigned          page;
    int unsigned          frame;
    int unsigned          i;
    xlat_t                res;
    offset = laddr & ((AddrWidth'(1) << OFFSET_WIDTH) - AddrWidth'(1));
    page   = (32'(laddr) >> OFFSET_WIDTH) % PAGE_COUNT;
    frame  = 0;
    res    = '0;
    for (i = 0; i < tlb_fill; i++) begin
      if (!res.tlb_hit && tlb_tag[i] == PageW'(page)) begin
        res.tlb_hit = 1'b1;
        frame = tlb_frm[i];
      end
    end
    if (!res.tlb_hit) begin
      if (page_mapped[page]) begin
        frame = page_frm[page];
      end else begin
        res.page_fault = 1'b1;
        frame = free_frame;
        if (free_frame < PAGE_COUNT) free_frame++;
        page_mapped[page] = 1'b1;
        page_frm[page] = PageW'(frame);
      end
      tlb_tag[tlb_ptr] = PageW'(page);
      tlb_frm[tlb_ptr] = PageW'(frame);
      tlb_ptr = (tlb_ptr + 1) % TLB_ENTRIES;
      if (tlb_fill < TLB_ENTRIES) tlb_fill++;
    end
    res.phys_addr = AddrWidth'((frame << OFFSET_WIDTH) | 32'(offset));
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_xlats.delete();
      tlb_fill   = 0;
      tlb_ptr    = 0;
      free_frame = '0;
      mismatches = 0;
      hits       = 0;
      faults     = 0;
      for (int unsigned p = 0; p < PAGE_COUNT; p++) page_mapped[p] = 1'b0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{physical_address_i, tlb_hit_i, page_fault_i};
        if (pending_xlats.size() == 0) begin
          $error("result beat with nothing expected: physical_address 0x%04h", got.phys_addr);
          mismatches++;
        end else begin
          want = pending_xlats.pop_front();
          if (got.phys_addr !== want.phys_addr) begin
            $error("physical_address: expected 0x%04h, got 0x%04h",
                   want.phys_addr, got.phys_addr);
            mismatches++;
          end
          if (got.tlb_hit !== want.tlb_hit) begin
            $error("tlb_hit: expected %0b, got %0b", want.tlb_hit, got.tlb_hit);
            mismatches++;
          end
          if (got.page_fault !== want.page_fault) begin
            $error("page_fault: expected %0b, got %0b", want.page_fault, got.page_fault);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = translate(logical_address_i);
        pending_xlats.push_back(want);
        hits   += want.tlb_hit;
        faults += want.page_fault;
      end
    end
    mismatch_count_o <= mismatches;
    outstanding_o    <= pending_xlats.size();
    hit_count_o      <= hits;
    fault_count_o    <= faults;
  end

endmodule

// ----- tb/sv/tlb_page_table_translator_core_tb.sv -----
`timescale 1ns / 100ps

module tlb_page_table_translator_core_tb;
  import tlbpt_pkg::*;

  localparam int unsigned TlbEntries  = 16;
  localparam int unsigned PageCount   = 256;
  localparam int unsigned OffsetWidth = 8;
  localparam int unsigned RandomItems = 1030;
  localparam int unsigned IdleLimit   = 5000;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [AddrWidth-1:0] laddr     = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [AddrWidth-1:0] paddr;
  logic                 hit;
  logic                 fault;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned hits;
  int unsigned faults;
  int unsigned sent        = 0;
  int unsigned idle_cycles = 0;
  stall_mode_e stall_mode  = STALL_NONE;
  int unsigned stall_left  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tlb_page_table_translator_core #(
    .TLB_ENTRIES (TlbEntries),
    .PAGE_COUNT  (PageCount),
    .OFFSET_WIDTH(OffsetWidth)
  ) dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .logical_address_i (laddr),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .physical_address_o(paddr),
    .tlb_hit_o         (hit),
    .page_fault_o      (fault)
  );

  tlb_page_table_translator_checker #(
    .TLB_ENTRIES (TlbEntries),
    .PAGE_COUNT  (PageCount),
    .OFFSET_WIDTH(OffsetWidth)
  ) checker_i (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .logical_address_i (laddr),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .physical_address_i(paddr),
    .tlb_hit_i         (hit),
    .page_fault_i      (fault),
    .mismatch_count_o  (mismatches),
    .outstanding_o     (outstanding),
    .hit_count_o       (hits),
    .fault_count_o     (faults)
  );

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(STALL_NONE, STALL_PERIODIC));
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_left % 5 < 3);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_beat(input logic [AddrWidth-1:0] addr);
    in_valid <= 1'b1;
    laddr    <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic pause(input int unsigned cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned directed;
    int unsigned burst_len;
    int unsigned ws_size;
    int unsigned next_drain;
    logic [7:0]  ws_base;
    logic [7:0]  page_sel;
    bit          local_burst;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // fault, hit, the top page, then overflow the TLB so both get evicted
    send_beat(16'h0000);
    send_beat(16'h00FF);
    pause($urandom_range(0, 4));
    send_beat(16'hFFFF);
    send_beat(16'hFF00);
    for (int unsigned p = 1; p <= TlbEntries; p++) begin
      send_beat({8'(p), 8'(p * 17)});
      if (p % 5 == 0) pause($urandom_range(1, 6));
    end
    send_beat(16'h0012);
    send_beat(16'hFF34);
    send_beat(16'h1080);
    drain();

    directed   = sent;
    next_drain = sent + 200;
    ws_size    = 1;
    ws_base    = '0;
    while (sent < directed + RandomItems) begin
      burst_len   = $urandom_range(1, 24);
      local_burst = ($urandom_range(0, 9) < 7);
      if (local_burst) begin
        ws_size = $urandom_range(1, 24);
        ws_base = 8'($urandom);
      end
      repeat (burst_len) begin
        if (local_burst) begin
          page_sel = ws_base + 8'($urandom_range(0, ws_size - 1));
          send_beat({page_sel, 8'($urandom)});
        end else begin
          send_beat(16'($urandom));
        end
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
      if (sent >= next_drain) begin
        drain();
        next_drain += 200;
      end
    end

    drain();
    repeat (8) @(posedge clk);

    $display("Translated %0d logical addresses: %0d TLB hits, %0d page faults,",
             sent, hits, faults);
    $display("%0d misses served from the page table.", sent - hits - faults);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
